// ===== rtl/pei_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pei_pkg;

	localparam int unsigned VEC_W   = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned AXIS_W  = 2;
	localparam int unsigned NUM_AX  = 3;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFGA_W  = 2;
	localparam int unsigned S_DATA_W = 96;
	localparam int unsigned M_DATA_W = 192;
	localparam int unsigned USER_W  = 2;

	// Operation codes carried on the slave-side tuser.
	localparam logic [OP_W-1:0] OP_ADD_FORCE = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP      = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_POS  = 2'd2;
	localparam logic [OP_W-1:0] OP_LOAD_VEL  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFGA_W-1:0] CFG_TIME_STEP = 2'd0;
	localparam logic [CFGA_W-1:0] CFG_DAMPING   = 2'd1;
	localparam logic [CFGA_W-1:0] CFG_INV_MASS  = 2'd2;
	localparam logic [CFGA_W-1:0] CFG_LIFETIME  = 2'd3;

	// Multiply phases of one integration step.
	localparam logic [1:0] PH_ACCEL = 2'd0;  // force * inverse mass
	localparam logic [1:0] PH_KICK  = 2'd1;  // velocity += accel * dt
	localparam logic [1:0] PH_DAMP  = 2'd2;  // velocity *= damping
	localparam logic [1:0] PH_DRIFT = 2'd3;  // position += velocity * dt

	localparam logic [15:0] RST_TIME_STEP = 16'd1092;
	localparam logic [16:0] RST_DAMPING   = 17'd65536;
	localparam logic [31:0] RST_INV_MASS  = 32'd65536;
	localparam logic [30:0] RST_LIFETIME  = 31'd6553600;

	typedef struct packed {
		logic              apply_op;  // apply the accepted item's simple update
		logic              issue;     // start one multiply in the shared pipeline
		logic [1:0]        phase;
		logic [AXIS_W-1:0] axis;
		logic              finish;    // close a step: life, flag, force clear
		logic              load_out;  // capture the state into the output register
	} pei_cmd_t;

	typedef struct packed {
		logic alive;
	} pei_sts_t;

	function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			sat_add32 = s[32] ? 32'sh80000000 : 32'sh7fffffff;
		else
			sat_add32 = s[31:0];
	endfunction

	// Round the magnitude product to nearest (ties away from zero), apply the
	// sign and saturate to the signed 32-bit range.
	function automatic logic signed [31:0] qround(input logic [PROD_W-1:0] prod,
		input logic neg);
		logic [PROD_W-1:0] r;
		logic              big;
		r   = (prod + 64'd32768) >> FRAC_W;
		big = |r[47:31];
		if (neg)
			qround = big ? 32'sh80000000 : -$signed(r[31:0]);
		else
			qround = big ? 32'sh7fffffff : $signed(r[31:0]);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/particle_euler_integrator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-particle integrator in signed Q16.16. Each transfer on the slave side is
// one operation chosen by s_tuser: add a force, take one semi-implicit Euler step,
// load a position (which revives the particle, restarts its life from the
// lifetime register and clears the force) or load a velocity. Every operation
// yields exactly one result transfer carrying the position, velocity, alive flag
// and grounded flag after the operation. Add force, load and a step while dead
// go straight to the output register once applied; a step while alive first
// runs the twelve products that share one pipelined multiplier (three stages,
// the three axes interleaved, four dependent phases) and then closes the step.
// One item is in flight at a time; the output register holds a finished result
// until it is taken, and a new item is accepted while it waits. Products round
// to nearest with ties away from zero and every product and sum saturates.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata
// and should only be written while the block is idle.

module particle_euler_integrator import pei_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFGA_W-1:0]   cfg_addr,   // 0 time_step, 1 damping_per_step,
	                                             // 2 inverse_mass, 3 lifetime
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,    // vec_x, vec_y, vec_z
	input  wire logic [USER_W-1:0]   s_tuser,    // op
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	output logic [USER_W-1:0]        m_tuser     // alive, grounded
);

	pei_cmd_t cmd;
	pei_sts_t sts;

	// The controller sequences the step; the datapath holds all particle state,
	// the configuration registers, the shared multiplier and the output register.
	pei_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_op     (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	pei_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_op      (s_tuser),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/pei_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pei_ctrl import pei_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [OP_W-1:0] s_op,
	input  wire logic            m_tready,
	output logic                 m_tvalid,
	input  wire pei_sts_t        sts,
	output pei_cmd_t             cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_STEP   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	// Last multiply issues at count 14; its write-back lands at the end of count 17.
	localparam logic [4:0] LAST_CNT = 5'd17;

	logic [1:0] state_q, state_nx;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd          = '0;
		state_nx     = state_q;
		cmd.phase    = cnt_q[3:2];
		cmd.axis     = cnt_q[1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.apply_op = 1'b1;
					if (s_op == OP_STEP && sts.alive)
						state_nx = ST_STEP;
					else
						state_nx = ST_DONE;
				end
			end
			ST_STEP: begin
				cmd.issue = !cnt_q[4] && (cnt_q[1:0] != 2'd3);
				if (cnt_q == LAST_CNT)
					state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_STEP)
				cnt_q <= cnt_q + 5'd1;
			else
				cnt_q <= '0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pei_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pei_dp import pei_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFGA_W-1:0]   cfg_addr,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic [OP_W-1:0]     s_op,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire pei_cmd_t            cmd,
	output pei_sts_t                 sts,
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic [USER_W-1:0]        m_tuser
);

	logic [15:0] dt_q;
	logic [16:0] damp_q;
	logic [31:0] imass_q;
	logic [30:0] life_cfg_q;

	logic signed [31:0] pos_q [NUM_AX];
	logic signed [31:0] vel_q [NUM_AX];
	logic signed [31:0] frc_q [NUM_AX];
	logic signed [31:0] vec   [NUM_AX];
	logic signed [31:0] life_q;
	logic               alive_q;

	// Multiply pipeline: operand select, product, round and saturate.
	logic               v_s1, v_s2, v_s3;
	logic [1:0]         ph_s1, ph_s2, ph_s3;
	logic [AXIS_W-1:0]  ax_s1, ax_s2, ax_s3;
	logic [31:0]        mag_s1, mb_s1;
	logic               neg_s1, neg_s2;
	logic signed [31:0] add_s1, add_s2, add_s3;
	logic [PROD_W-1:0]  prod_s2;
	logic signed [31:0] q_s3;

	logic signed [31:0] op_a, op_add;
	logic [31:0]        op_b;
	logic signed [31:0] wb_sum;
	logic signed [32:0] life_diff;
	logic signed [31:0] life_nx;

	assign vec[0] = s_tdata[31:0];
	assign vec[1] = s_tdata[63:32];
	assign vec[2] = s_tdata[95:64];

	assign sts.alive = alive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q       <= RST_TIME_STEP;
			damp_q     <= RST_DAMPING;
			imass_q    <= RST_INV_MASS;
			life_cfg_q <= RST_LIFETIME;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TIME_STEP: dt_q       <= cfg_wdata[15:0];
				CFG_DAMPING:   damp_q     <= cfg_wdata[16:0];
				CFG_INV_MASS:  imass_q    <= cfg_wdata;
				CFG_LIFETIME:  life_cfg_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		op_a   = frc_q[cmd.axis];
		op_b   = imass_q;
		op_add = vel_q[cmd.axis];
		case (cmd.phase)
			PH_ACCEL: begin
				op_a = frc_q[cmd.axis];
				op_b = imass_q;
			end
			PH_KICK: begin
				op_a = frc_q[cmd.axis];
				op_b = {16'd0, dt_q};
			end
			PH_DAMP: begin
				op_a = vel_q[cmd.axis];
				op_b = {15'd0, damp_q};
			end
			PH_DRIFT: begin
				op_a   = vel_q[cmd.axis];
				op_b   = {16'd0, dt_q};
				op_add = pos_q[cmd.axis];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1   <= cmd.phase;
		ax_s1   <= cmd.axis;
		neg_s1  <= op_a[31];
		mag_s1  <= op_a[31] ? 32'(-op_a) : op_a;
		mb_s1   <= op_b;
		add_s1  <= op_add;

		ph_s2   <= ph_s1;
		ax_s2   <= ax_s1;
		neg_s2  <= neg_s1;
		prod_s2 <= {32'd0, mag_s1} * {32'd0, mb_s1};
		add_s2  <= add_s1;

		ph_s3   <= ph_s2;
		ax_s3   <= ax_s2;
		q_s3    <= qround(prod_s2, neg_s2);
		add_s3  <= add_s2;
	end

	assign wb_sum    = sat_add32(add_s3, q_s3);
	assign life_diff = {life_q[31], life_q} - $signed({17'd0, dt_q});
	assign life_nx   = (life_diff[32] != life_diff[31]) ? 32'sh80000000 : life_diff[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AX; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				frc_q[i] <= '0;
			end
			life_q  <= '0;
			alive_q <= 1'b0;
		end else begin
			if (cmd.apply_op) begin
				case (s_op)
					OP_ADD_FORCE: begin
						for (int i = 0; i < NUM_AX; i++)
							frc_q[i] <= sat_add32(frc_q[i], vec[i]);
					end
					OP_LOAD_POS: begin
						for (int i = 0; i < NUM_AX; i++) begin
							pos_q[i] <= vec[i];
							frc_q[i] <= '0;
						end
						life_q  <= {1'b0, life_cfg_q};
						alive_q <= 1'b1;
					end
					OP_LOAD_VEL: begin
						for (int i = 0; i < NUM_AX; i++)
							vel_q[i] <= vec[i];
					end
					default: ;
				endcase
			end
			if (v_s3) begin
				case (ph_s3)
					PH_ACCEL: frc_q[ax_s3] <= q_s3;
					PH_KICK:  vel_q[ax_s3] <= wb_sum;
					PH_DAMP:  vel_q[ax_s3] <= q_s3;
					PH_DRIFT: pos_q[ax_s3] <= wb_sum;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				for (int i = 0; i < NUM_AX; i++)
					frc_q[i] <= '0;
				life_q  <= life_nx;
				alive_q <= (life_nx > 0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
			m_tuser <= {(pos_q[1][31] || (pos_q[1] == 0)), alive_q};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pei_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pei_checker import pei_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [S_DATA_W-1:0] s_tdata,
	input wire logic [USER_W-1:0]   s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [USER_W-1:0]   m_tuser
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one item is worked on at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// A new result is only offered after the block was busy with an item.
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result offered without an item");

	// A position load into an empty output revives the particle at that position.
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_LOAD_POS && !m_tvalid |->
		##2 m_tvalid && m_tuser[0] && m_tdata[95:0] == $past(s_tdata, 2))
		else $error("position load not reflected");

	// A velocity load into an empty output shows that velocity.
	a_load_vel: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_LOAD_VEL && !m_tvalid |->
		##2 m_tvalid && m_tdata[191:96] == $past(s_tdata, 2))
		else $error("velocity load not reflected");

endmodule

bind particle_euler_integrator pei_checker u_pei_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/particle_euler_integrator_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the single-particle Euler integrator.
//
// Every operation on the slave side yields exactly one result transfer, so the
// bench keeps its own copy of the particle (position, velocity, force sum,
// life and alive flag) together with its own copy of the four configuration
// registers. When an operation transfer is accepted, the particle copy is
// advanced and the state it should show afterwards is queued. Each result
// transfer is then compared field by field with the oldest queued state.
//
// The run has two parts. A short directed plan covers the extremes of every
// vector field, all four operations, stepping and adding force while dead,
// loading a velocity, a zero lifetime, a zero time step, damping above one and
// saturating products. Where the outcome is obvious, the plan row carries the
// expected state typed in directly. The random part then works through phases
// with fresh register settings, mostly as well-formed runs: load a position,
// perhaps load a velocity, then a few rounds of added forces and steps. Stray
// operations with random content are mixed in.
//
// Both sides pause at random. One phase runs with no pauses at all, and in
// another the receiver holds off for a long stretch so that the block fills up
// and stops taking operations.

module particle_euler_integrator_tb;
	import pei_pkg::*;

	localparam int     PLAN_LEN   = 35;
	localparam int     PHASES     = 8;
	localparam int     PHASE_OPS  = 100;
	localparam int     GAP_PCT    = 24;
	localparam int     HOLD_LEN   = 400;
	localparam int     CYCLE_CAP  = 300000;
	localparam longint Q_MAX      = 64'sd2147483647;
	localparam longint Q_MIN      = -64'sd2147483648;

	// One observed or predicted result: the six vector words in the order in
	// which they travel on m_tdata, then the two flags from m_tuser.
	typedef struct packed {
		logic [0:5][31:0] words;
		logic             alive;
		logic             grounded;
	} particle_obs_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// A row of the directed plan is either an operation or a register write.
	// For a write, code is the register index and arg[0] the value.
	typedef struct packed {
		row_kind_t        kind;
		logic [1:0]       code;
		logic [0:2][31:0] arg;
		logic             has_lit;
		particle_obs_t    lit;
	} plan_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFGA_W-1:0]   cfg_addr  = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [USER_W-1:0]   s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [USER_W-1:0]   m_tuser;

	// The bench's own copy of the particle and of the register file.
	logic signed [31:0] part_pos [3];
	logic signed [31:0] part_vel [3];
	logic signed [31:0] part_force [3];
	logic signed [31:0] part_life;
	logic               part_alive;
	logic [15:0]        reg_dt       = RST_TIME_STEP;
	logic [16:0]        reg_damp     = RST_DAMPING;
	logic [31:0]        reg_inv_mass = RST_INV_MASS;
	logic [30:0]        reg_lifetime = RST_LIFETIME;

	particle_obs_t states_due [$];
	int            mismatches    = 0;
	int            items_sent    = 0;
	int            cycles        = 0;
	bit            steady        = 1'b0;
	int            hold_requests = 0;

	string field_label [8] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
		"alive", "grounded"};

	// Directed plan. Rows with has_lit set carry the expected state outright;
	// all other rows are checked against the particle copy.
	plan_row_t plan [PLAN_LEN] = '{
		// Straight after reset the particle is dead and sits at the origin.
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b1,
			'{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 1'b1}},
		// Force gathers while dead; the second add saturates x and y and brings z back to zero.
		'{ROW_ITEM, OP_ADD_FORCE, '{32'h7fffffff, 32'h80000000, 32'h00000001}, 1'b1,
			'{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 1'b1}},
		'{ROW_ITEM, OP_ADD_FORCE, '{32'h7fffffff, 32'h80000000, 32'hffffffff}, 1'b1,
			'{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 1'b1}},
		// A step while dead leaves everything as it was.
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b1,
			'{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 1'b1}},
		// Loading a velocity touches neither the life nor the alive flag.
		'{ROW_ITEM, OP_LOAD_VEL, '{32'h7fffffff, 32'h80000000, 32'h00010000}, 1'b1,
			'{'{32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000},
			1'b0, 1'b1}},
		// Loading a position revives the particle and clears the force.
		'{ROW_ITEM, OP_LOAD_POS, '{32'h80000000, 32'h7fffffff, 32'hffffffff}, 1'b1,
			'{'{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000,
			32'h00010000}, 1'b1, 1'b0}},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_ADD_FORCE, '{32'h00640000, 32'hffff0000, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		// Height zero and just below zero both count as grounded.
		'{ROW_ITEM, OP_LOAD_POS, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_LOAD_POS, '{32'h0, 32'hffffffff, 32'h0}, 1'b0, '0},
		// Largest inverse mass: the acceleration product saturates.
		'{ROW_REG, CFG_INV_MASS, '{32'hffffffff, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_ADD_FORCE, '{32'h7fffffff, 32'h80000000, 32'h00008000}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		// Zero time step: the step only damps velocity and clears the force.
		'{ROW_REG, CFG_TIME_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_DAMPING, '{32'h00008000, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		// Zero lifetime with the longest step and damping above one.
		'{ROW_REG, CFG_LIFETIME, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_TIME_STEP, '{32'h0000ffff, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_DAMPING, '{32'h0001ffff, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_INV_MASS, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_LOAD_POS, '{32'h00010000, 32'h00010000, 32'h00010000}, 1'b0, '0},
		'{ROW_ITEM, OP_LOAD_VEL, '{32'h40000000, 32'hc0000000, 32'h00001000}, 1'b1,
			'{'{32'h00010000, 32'h00010000, 32'h00010000, 32'h40000000, 32'hc0000000,
			32'h00001000}, 1'b1, 1'b0}},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_ADD_FORCE, '{32'hffffffff, 32'hffffffff, 32'hffffffff}, 1'b0, '0},
		// Longest lifetime, shortest step, and damping that wipes out velocity.
		'{ROW_REG, CFG_LIFETIME, '{32'h7fffffff, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_TIME_STEP, '{32'h00000001, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_DAMPING, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_REG, CFG_INV_MASS, '{32'h00000001, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_LOAD_POS, '{32'h7fffffff, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
		'{ROW_ITEM, OP_ADD_FORCE, '{32'h00100000, 32'hfff00000, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_LOAD_VEL, '{32'h12345678, 32'hedcba988, 32'h0}, 1'b0, '0},
		'{ROW_ITEM, OP_STEP, '{32'h0, 32'h0, 32'h0}, 1'b0, '0}
	};

	particle_euler_integrator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // vec_x, vec_y, vec_z
		.s_tuser   (s_tuser),     // op
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),     // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
		.m_tuser   (m_tuser)      // alive, grounded
	);

	always #2 clk = ~clk;

	// Clamp a wide intermediate value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input longint v);
		if (v > Q_MAX)
			return 32'sh7fffffff;
		if (v < Q_MIN)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Signed Q16.16 value times an unsigned fixed-point factor. The magnitude
	// is rounded half away from zero, the sign is put back afterwards, and the
	// result is saturated.
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
		input logic [31:0] b);
		logic [63:0] mag;
		logic [63:0] r;
		mag = a[31] ? 64'(-longint'(a)) : 64'(longint'(a));
		r   = (mag * {32'd0, b} + 64'd32768) >> 16;
		return a[31] ? sat32(-longint'(r)) : sat32(longint'(r));
	endfunction

	// Apply one operation to the particle copy and return the state that the
	// block should report for it.
	task automatic advance_particle(input logic [OP_W-1:0] op, input logic [0:2][31:0] v,
		output particle_obs_t obs);
		logic signed [31:0] accel;
		logic signed [31:0] vel;
		case (op)
			OP_ADD_FORCE: begin
				for (int i = 0; i < 3; i++)
					part_force[i] = sat32(longint'(part_force[i]) + longint'($signed(v[i])));
			end
			OP_STEP: begin
				// Semi-implicit order: the new velocity moves the position.
				if (part_alive) begin
					for (int i = 0; i < 3; i++) begin
						accel = fx_mul(part_force[i], reg_inv_mass);
						vel   = sat32(longint'(part_vel[i]) +
							longint'(fx_mul(accel, {16'd0, reg_dt})));
						vel   = fx_mul(vel, {15'd0, reg_damp});
						part_vel[i]   = vel;
						part_pos[i]   = sat32(longint'(part_pos[i]) +
							longint'(fx_mul(vel, {16'd0, reg_dt})));
						part_force[i] = '0;
					end
					part_life = sat32(longint'(part_life) - longint'(reg_dt));
					if (part_life <= 0)
						part_alive = 1'b0;
				end
			end
			OP_LOAD_POS: begin
				for (int i = 0; i < 3; i++) begin
					part_pos[i]   = v[i];
					part_force[i] = '0;
				end
				part_life  = {1'b0, reg_lifetime};
				part_alive = 1'b1;
			end
			OP_LOAD_VEL: begin
				for (int i = 0; i < 3; i++)
					part_vel[i] = v[i];
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			obs.words[i]     = part_pos[i];
			obs.words[3 + i] = part_vel[i];
		end
		obs.alive    = part_alive;
		obs.grounded = (part_pos[1] <= 0);
	endtask

	function automatic logic [31:0] field_of(input particle_obs_t obs, input int idx);
		if (idx < 6)
			return obs.words[idx];
		return (idx == 6) ? {31'd0, obs.alive} : {31'd0, obs.grounded};
	endfunction

	// Operand words lean towards moderate magnitudes so that the arithmetic
	// mostly stays out of saturation, with full-range words and the extremes
	// mixed in.
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			case ($urandom_range(0, 3))
				0:       w = 32'h7fffffff;
				1:       w = 32'h80000000;
				2:       w = 32'hffffffff;
				default: w = 32'h0;
			endcase
		end else if (pick < 30) begin
			w = $urandom;
		end else begin
			w = $urandom_range(0, 32'h00400000);
			if ($urandom_range(0, 1))
				w = -w;
		end
		return w;
	endfunction

	function automatic logic [0:2][31:0] rand_vec();
		return {rand_word(), rand_word(), rand_word()};
	endfunction

	// Offer one operation, starting at a falling edge, and return at the falling
	// edge after its transfer. The expected state is worked out at the
	// accepting edge, so it follows the order in which the block takes items.
	task automatic offer_item(input logic [OP_W-1:0] op, input logic [0:2][31:0] v,
		input logic has_lit, input particle_obs_t lit);
		particle_obs_t want;
		while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {v[2], v[1], v[0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_particle(op, v, want);
		states_due.push_back(has_lit ? lit : want);
		items_sent++;
		@(negedge clk);
	endtask

	// Wait until every result has been taken, then let the block settle before
	// anything else happens.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (states_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register writes only ever happen with the block drained.
	task automatic write_reg(input logic [CFGA_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_TIME_STEP: reg_dt       = val[15:0];
			CFG_DAMPING:   reg_damp     = val[16:0];
			CFG_INV_MASS:  reg_inv_mass = val;
			CFG_LIFETIME:  reg_lifetime = val[30:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] dt;
		logic [16:0] damp;
		logic [31:0] inv_mass;
		logic [31:0] life;
		int          first;
		for (int i = 0; i < 3; i++) begin
			part_pos[i]   = '0;
			part_vel[i]   = '0;
			part_force[i] = '0;
		end
		part_life  = '0;
		part_alive = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_REG)
				write_reg(plan[r].code, plan[r].arg[0]);
			else
				offer_item(plan[r].code, plan[r].arg, plan[r].has_lit, plan[r].lit);
		end

		for (int p = 0; p < PHASES; p++) begin
			// Phase 0 tops out time step, inverse mass and lifetime, damping at one;
			// phase 1 has time step one, all else zero; the rest draw fresh settings.
			if (p == 0) begin
				dt       = 16'hffff;
				damp     = 17'd65536;
				inv_mass = 32'hffffffff;
				life     = 32'h7fffffff;
			end else if (p == 1) begin
				dt       = 16'd1;
				damp     = '0;
				inv_mass = '0;
				life     = '0;
			end else begin
				case ($urandom_range(0, 3))
					0:       dt = 16'hffff;
					1:       dt = $urandom_range(1, 65535);
					default: dt = $urandom_range(64, 4096);
				endcase
				case ($urandom_range(0, 3))
					0:       damp = 17'd65536;
					1:       damp = $urandom_range(0, 65536);
					default: damp = $urandom_range(62000, 65536);
				endcase
				inv_mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(16384, 262144);
				// Most lifetimes last two to forty steps so that deaths are common.
				if ($urandom_range(0, 3) == 0)
					life = $urandom_range(0, 32'h7fffffff);
				else
					life = dt * $urandom_range(2, 40);
			end
			write_reg(CFG_TIME_STEP, {16'd0, dt});
			write_reg(CFG_DAMPING, {15'd0, damp});
			write_reg(CFG_INV_MASS, inv_mass);
			write_reg(CFG_LIFETIME, life);

			steady = (p == 3);
			if (p == 5)
				hold_requests++;

			first = items_sent;
			while (items_sent - first < PHASE_OPS) begin
				if ($urandom_range(0, 9) == 0) begin
					offer_item(OP_W'($urandom_range(0, 3)), rand_vec(), 1'b0, '0);
				end else begin
					offer_item(OP_LOAD_POS, rand_vec(), 1'b0, '0);
					if ($urandom_range(0, 1))
						offer_item(OP_LOAD_VEL, rand_vec(), 1'b0, '0);
					repeat ($urandom_range(1, 8)) begin
						repeat ($urandom_range(0, 3))
							offer_item(OP_ADD_FORCE, rand_vec(), 1'b0, '0);
						offer_item(OP_STEP, rand_vec(), 1'b0, '0);
					end
				end
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && states_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Receiver side: random pauses, none during the steady phase, and one long
	// hold-off on request so that the result register stays full and the
	// operation side backs up.
	int stall_left = 0;
	int holds_seen = 0;

	always @(negedge clk) begin
		if (holds_seen != hold_requests) begin
			holds_seen = hold_requests;
			stall_left = HOLD_LEN;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
		end
	end

	// Compare every result transfer with the oldest queued state.
	always @(posedge clk) begin : result_check
		particle_obs_t got;
		particle_obs_t want;
		if (arst_n && m_tvalid && m_tready) begin
			for (int i = 0; i < 6; i++)
				got.words[i] = m_tdata[32 * i +: 32];
			got.alive    = m_tuser[0];
			got.grounded = m_tuser[1];
			if (states_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transfer with nothing outstanding", $time);
			end else begin
				want = states_due.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (field_of(got, i) !== field_of(want, i)) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: %s expected %h, got %h", $time, field_label[i],
								field_of(want, i), field_of(got, i));
					end
				end
			end
		end
	end

	// Guard against a hang: a result that never arrives ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/pei_pkg.sv
rtl/pei_ctrl.sv
rtl/pei_dp.sv
rtl/particle_euler_integrator.sv
rtl/pei_checker.sv
tb/particle_euler_integrator_tb.sv
